[rtl/pmdm_pkg.sv]
`timescale 1ns / 1ps
package pmdm_pkg;

  localparam int unsigned IdStoreDepth = 64;

  localparam int unsigned PosW   = 20;
  localparam int unsigned IdW    = 16;
  localparam int unsigned DistW  = 17;
  localparam int unsigned SqW    = 34;
  localparam int unsigned DsqW   = 42;
  localparam int unsigned SumW   = 48;
  localparam int unsigned CntW   = 24;
  localparam int unsigned CcW    = 7;
  localparam int unsigned IterW  = 6;

  localparam logic [SqW-1:0]   InitSq   = 34'd10000000000;
  localparam logic [DistW-1:0] InitRoot = 17'd100000;
  localparam logic [SumW-1:0]  SumMax   = {SumW{1'b1}};
  localparam logic [CntW-1:0]  CntMax   = {CntW{1'b1}};
  localparam logic [IterW-1:0] SqrtSteps = 6'd16;
  localparam logic [IterW-1:0] DivSteps  = 6'd47;

  // configuration register indexes
  localparam logic [1:0] RegStartX    = 2'd0;
  localparam logic [1:0] RegGoalX     = 2'd1;
  localparam logic [1:0] RegCollision = 2'd2;

  // result status codes
  localparam logic [1:0] StBeforeStart = 2'd0;
  localparam logic [1:0] StMeasured    = 2'd1;
  localparam logic [1:0] StPastGoal    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_SRCH, S_SCMP, S_FEND, S_SQRT, S_ACCUM, S_DIV, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic idx_clr;
    logic srd;
    logic sinc;
    logic swrite;
    logic full_set;
    logic sqrt_start;
    logic sqrt_step;
    logic accum;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic measuring;
    logic last;
    logic hit;
    logic idx_end;
    logic room;
    logic match;
    logic iter_done;
    logic out_busy;
  } stat_t;

endpackage

[rtl/pmdm_if.sv]
`timescale 1ns / 1ps
interface pmdm_in_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] robot_x;
  logic signed [19:0] robot_y;
  logic signed [19:0] agent_x;
  logic signed [19:0] agent_y;
  logic [15:0]        agent_id;
  logic               agent_present;
  logic               frame_last;

  modport source (output valid, robot_x, robot_y, agent_x, agent_y, agent_id,
                  agent_present, frame_last, input ready);
  modport sink (input valid, robot_x, robot_y, agent_x, agent_y, agent_id,
                agent_present, frame_last, output ready);
endinterface

interface pmdm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [16:0] frame_min_mm;
  logic [16:0] overall_min_mm;
  logic [16:0] mean_min_mm;
  logic [6:0]  collision_count;
  logic        id_store_full;

  modport source (output valid, status, frame_min_mm, overall_min_mm, mean_min_mm,
                  collision_count, id_store_full, input ready);
  modport sink (input valid, status, frame_min_mm, overall_min_mm, mean_min_mm,
                collision_count, id_store_full, output ready);
endinterface

[rtl/pmdm_ctrl.sv]
`timescale 1ns / 1ps
module pmdm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pmdm_pkg::stat_t stat,
  output pmdm_pkg::cmd_t  cmd
);

  pmdm_pkg::state_t state, state_next, after_item;

  always_ff @(posedge clk) begin
    if (rst) state <= pmdm_pkg::S_IDLE;
    else     state <= state_next;
  end

  // where to go once an item's own work is over
  always_comb begin
    if (!stat.last)          after_item = pmdm_pkg::S_IDLE;
    else if (stat.measuring) after_item = pmdm_pkg::S_FEND;
    else                     after_item = pmdm_pkg::S_DONE;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pmdm_pkg::S_IDLE:  if (in_valid) state_next = pmdm_pkg::S_MUL;
      pmdm_pkg::S_MUL:   state_next = pmdm_pkg::S_ACC;
      pmdm_pkg::S_ACC:   state_next = stat.hit ? pmdm_pkg::S_SRCH : after_item;
      pmdm_pkg::S_SRCH:  state_next = stat.idx_end ? after_item : pmdm_pkg::S_SCMP;
      pmdm_pkg::S_SCMP:  state_next = stat.match ? after_item : pmdm_pkg::S_SRCH;
      pmdm_pkg::S_FEND:  state_next = pmdm_pkg::S_SQRT;
      pmdm_pkg::S_SQRT:  if (stat.iter_done) state_next = pmdm_pkg::S_ACCUM;
      pmdm_pkg::S_ACCUM: state_next = pmdm_pkg::S_DIV;
      pmdm_pkg::S_DIV:   if (stat.iter_done) state_next = pmdm_pkg::S_DONE;
      pmdm_pkg::S_DONE:  if (!stat.out_busy) state_next = pmdm_pkg::S_IDLE;
      default:           state_next = pmdm_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      pmdm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      pmdm_pkg::S_MUL: cmd.mul = 1'b1;
      pmdm_pkg::S_ACC: begin
        cmd.acc     = 1'b1;
        cmd.idx_clr = 1'b1;
      end
      pmdm_pkg::S_SRCH: begin
        if (stat.idx_end) begin
          cmd.swrite   = stat.room;
          cmd.full_set = !stat.room;
        end else begin
          cmd.srd = 1'b1;
        end
      end
      pmdm_pkg::S_SCMP:  cmd.sinc = !stat.match;
      pmdm_pkg::S_FEND:  cmd.sqrt_start = 1'b1;
      pmdm_pkg::S_SQRT:  cmd.sqrt_step = 1'b1;
      pmdm_pkg::S_ACCUM: cmd.accum = 1'b1;
      pmdm_pkg::S_DIV:   cmd.div_step = 1'b1;
      pmdm_pkg::S_DONE:  cmd.out_load = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

[rtl/pmdm_dp.sv]
`timescale 1ns / 1ps
module pmdm_dp #(
  parameter int unsigned ID_STORE_DEPTH = pmdm_pkg::IdStoreDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [19:0]    cfg_data,
  pmdm_in_if.sink        in_ch,
  pmdm_out_if.source     out_ch,
  input  pmdm_pkg::cmd_t cmd,
  output pmdm_pkg::stat_t stat
);

  localparam int unsigned CW = $clog2(ID_STORE_DEPTH + 1);
  localparam int unsigned AW = (ID_STORE_DEPTH > 1) ? $clog2(ID_STORE_DEPTH) : 1;
  localparam logic [CW-1:0] DepthC = CW'(ID_STORE_DEPTH);

  // configuration
  logic signed [19:0] start_x, goal_x;
  logic [16:0]        coll_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x   <= 20'sd1000;
      goal_x    <= 20'sd18000;
      coll_dist <= 17'd200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmdm_pkg::RegStartX:    start_x   <= cfg_data;
        pmdm_pkg::RegGoalX:     goal_x    <= cfg_data;
        pmdm_pkg::RegCollision: coll_dist <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [20:0] ux, uy;
  logic [15:0] id;
  logic        present, last, measuring, past_goal;
  logic signed [20:0] dx, dy;

  assign dx = 21'(in_ch.agent_x) - 21'(in_ch.robot_x);
  assign dy = 21'(in_ch.agent_y) - 21'(in_ch.robot_y);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ux        <= dx[20] ? 21'(-dx) : 21'(dx);
      uy        <= dy[20] ? 21'(-dy) : 21'(dy);
      id        <= in_ch.agent_id;
      present   <= in_ch.agent_present;
      last      <= in_ch.frame_last;
      measuring <= (in_ch.robot_x > start_x) && (in_ch.robot_x <= goal_x);
      past_goal <= in_ch.robot_x > goal_x;
    end
  end

  // squares
  logic [41:0] sqx, sqy;
  logic [33:0] csq;
  logic [41:0] dsq;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sqx <= 42'(ux) * 42'(ux);
      sqy <= 42'(uy) * 42'(uy);
      csq <= 34'(coll_dist) * 34'(coll_dist);
    end
  end

  assign dsq = sqx + sqy;

  // frame minimum
  logic [33:0] frame_min_sq;
  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) frame_min_sq <= pmdm_pkg::InitSq;
    else if (cmd.acc && measuring && present && dsq < {8'd0, frame_min_sq})
      frame_min_sq <= dsq[33:0];
  end

  // collided id store
  logic [15:0]   ids [ID_STORE_DEPTH];
  logic [15:0]   rd_id;
  logic [CW-1:0] idx, count;
  logic          full_seen;

  always_ff @(posedge clk) begin
    if (cmd.swrite) ids[count[AW-1:0]] <= id;
    if (cmd.srd)    rd_id <= ids[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr)   idx <= '0;
    else if (cmd.sinc) idx <= idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      full_seen <= 1'b0;
    end else begin
      if (cmd.swrite)   count     <= count + 1'b1;
      if (cmd.full_set) full_seen <= 1'b1;
    end
  end

  // iteration counter shared by square root and divider
  logic [5:0] iter;
  always_ff @(posedge clk) begin
    if (cmd.sqrt_start)                 iter <= pmdm_pkg::SqrtSteps;
    else if (cmd.accum)                 iter <= pmdm_pkg::DivSteps;
    else if (cmd.sqrt_step || cmd.div_step) iter <= iter - 1'b1;
  end

  // floor square root, one result bit a step
  logic [33:0] sq_n;
  logic [18:0] sq_rem;
  logic [16:0] root;
  logic [20:0] rem_sh, trial;

  assign rem_sh = {sq_rem, sq_n[33:32]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_n   <= frame_min_sq;
      sq_rem <= '0;
      root   <= '0;
    end else if (cmd.sqrt_step) begin
      sq_n <= {sq_n[31:0], 2'b00};
      if (rem_sh >= trial) begin
        sq_rem <= 19'(rem_sh - trial);
        root   <= {root[15:0], 1'b1};
      end else begin
        sq_rem <= rem_sh[18:0];
        root   <= {root[15:0], 1'b0};
      end
    end
  end

  // accumulate minima
  logic [47:0] sum;
  logic [23:0] frames;
  logic [16:0] overall_root;
  logic [48:0] sum_add;
  logic [47:0] sum_new;
  logic [23:0] frames_new;

  assign sum_add    = {1'b0, sum} + 49'(root);
  assign sum_new    = sum_add[48] ? pmdm_pkg::SumMax : sum_add[47:0];
  assign frames_new = (frames == pmdm_pkg::CntMax) ? frames : frames + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum          <= '0;
      frames       <= '0;
      overall_root <= pmdm_pkg::InitRoot;
    end else if (cmd.accum) begin
      sum    <= sum_new;
      frames <= frames_new;
      if (root < overall_root) overall_root <= root;
    end
  end

  // restoring divider for the mean
  logic [47:0] dvd;
  logic [23:0] dv_rem;
  logic [24:0] dv_sh;
  logic        dv_ge;
  logic [16:0] mean;

  assign dv_sh = {dv_rem, dvd[47]};
  assign dv_ge = dv_sh >= {1'b0, frames};

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      dvd    <= sum_new;
      dv_rem <= '0;
    end else if (cmd.div_step) begin
      dvd    <= {dvd[46:0], dv_ge};
      dv_rem <= dv_ge ? 24'(dv_sh - {1'b0, frames}) : dv_sh[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) mean <= '0;
    else if (cmd.div_step && iter == '0) mean <= {dvd[15:0], dv_ge};
  end

  // result register
  logic out_valid;
  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.status          <= measuring ? pmdm_pkg::StMeasured :
                                past_goal ? pmdm_pkg::StPastGoal : pmdm_pkg::StBeforeStart;
      out_ch.frame_min_mm    <= measuring ? root : '0;
      out_ch.overall_min_mm  <= overall_root;
      out_ch.mean_min_mm     <= mean;
      out_ch.collision_count <= 7'(count);
      out_ch.id_store_full   <= full_seen;
    end
  end

  assign out_ch.valid = out_valid;

  // status to the controller
  assign stat.measuring = measuring;
  assign stat.last      = last;
  assign stat.hit       = measuring && present && dsq < {8'd0, csq};
  assign stat.idx_end   = idx == count;
  assign stat.room      = count < DepthC;
  assign stat.match     = rd_id == id;
  assign stat.iter_done = iter == '0;
  assign stat.out_busy  = out_valid && !out_ch.ready;

endmodule

[rtl/proximity_min_distance_monitor_unit.sv]
`timescale 1ns / 1ps
// Channel   Modport  Carries
// in_ch     sink     one agent item: robot and agent position, id, present, last
// out_ch    source   one frame result: status, minima, mean, collision count, full
// cfg_*     write    start_x_mm, goal_x_mm, collision_dist_mm by index 0..2
//
// An item is captured, squared and compared in turn. An agent within the collision
// distance then has each stored id read and compared, and a new id is stored when
// none matches. Every frame end loads the result; a measured one first runs the
// bit-serial square root and then the restoring divider for the mean.
// Reset is synchronous; the result register lets the next item in while a
// result waits, and a new result waits while the previous one is stalled.
module proximity_min_distance_monitor_unit #(
  parameter int unsigned ID_STORE_DEPTH = pmdm_pkg::IdStoreDepth
) (
  input  logic        clk,
  input  logic        rst,
  pmdm_in_if.sink     in_ch,
  pmdm_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  pmdm_pkg::cmd_t  cmd;
  pmdm_pkg::stat_t stat;

  pmdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pmdm_dp #(.ID_STORE_DEPTH(ID_STORE_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

[rtl/pmdm_checker.sv]
`timescale 1ns / 1ps
module pmdm_checker (
  input logic        clk,
  input logic        rst,
  pmdm_in_if.sink    in_ch,
  pmdm_out_if.source out_ch
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");

  // one item at a time
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item taken while busy");

  // unmeasured frames report no frame minimum
  a_fmin_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status != pmdm_pkg::StMeasured |-> out_ch.frame_min_mm == '0)
    else $error("frame minimum on unmeasured frame");

  // overall minimum includes this frame
  a_overall: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status == pmdm_pkg::StMeasured |->
      out_ch.overall_min_mm <= out_ch.frame_min_mm)
    else $error("overall minimum above frame minimum");

  // status code in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.status != 2'd3)
    else $error("bad status code");

endmodule

bind proximity_min_distance_monitor_unit pmdm_checker u_pmdm_checker (
  .clk    (clk),
  .rst    (rst),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

[tb/sv/tb_proximity_min_distance_monitor_unit.sv]
`timescale 1ns / 1ps
module tb_proximity_min_distance_monitor_unit;

  localparam longint unsigned InitSqVal = 64'd10000000000;
  localparam longint unsigned SumSat = (64'd1 << 48) - 1;
  localparam longint unsigned CntSat = (64'd1 << 24) - 1;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned LongHold = 400;

  typedef struct packed {
    logic [1:0]  status;
    logic [16:0] frame_min_mm;
    logic [16:0] overall_min_mm;
    logic [16:0] mean_min_mm;
    logic [6:0]  collision_count;
    logic        id_store_full;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = pmdm_pkg::RegStartX;
  logic [19:0] cfg_data = '0;

  pmdm_in_if in_ch ();
  pmdm_out_if out_ch ();

  proximity_min_distance_monitor_unit uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state
  longint signed   start_q, goal_q;
  longint unsigned coll_q;
  longint unsigned fmin_sq, omin_sq, min_sum, frames;
  logic [15:0]     ids [pmdm_pkg::IdStoreDepth];
  int unsigned     id_cnt;
  bit              full_q;

  report_t reports_due [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;
  int unsigned hold_cycles = 0;
  int unsigned hold_reqs = 0;
  int unsigned holds_done = 0;
  int unsigned rx_wait = 0;

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic reset_model();
    start_q = 1000; goal_q = 18000; coll_q = 200;
    fmin_sq = InitSqVal; omin_sq = InitSqVal; min_sum = 0; frames = 0;
    id_cnt = 0; full_q = 0;
  endtask

  task automatic predict_frame(logic signed [19:0] rx, ry, ax, ay, logic [15:0] id,
                               bit present, bit last);
    longint signed dx, dy;
    longint unsigned dsq, fm;
    bit measuring, known;
    report_t r;
    measuring = (rx > start_q) && (rx <= goal_q);
    if (measuring && present) begin
      dx = longint'(ax) - longint'(rx);
      dy = longint'(ay) - longint'(ry);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      dsq = dx * dx + dy * dy;
      if (dsq < fmin_sq) fmin_sq = dsq;
      if (dsq < coll_q * coll_q) begin
        known = 0;
        for (int i = 0; i < id_cnt; i++) if (ids[i] == id) known = 1;
        if (!known) begin
          if (id_cnt < pmdm_pkg::IdStoreDepth) begin
            ids[id_cnt] = id;
            id_cnt++;
          end else begin
            full_q = 1;
          end
        end
      end
    end
    if (last) begin
      fm = 0;
      if (measuring) begin
        r.status = pmdm_pkg::StMeasured;
        fm = floor_root(fmin_sq);
        min_sum = (SumSat - min_sum < fm) ? SumSat : min_sum + fm;
        if (fmin_sq < omin_sq) omin_sq = fmin_sq;
        if (frames < CntSat) frames++;
      end else if (rx > goal_q) begin
        r.status = pmdm_pkg::StPastGoal;
      end else begin
        r.status = pmdm_pkg::StBeforeStart;
      end
      fmin_sq = InitSqVal;
      r.frame_min_mm = fm[16:0];
      r.overall_min_mm = 17'(floor_root(omin_sq));
      r.mean_min_mm = 17'(frames != 0 ? min_sum / frames : 0);
      r.collision_count = 7'(id_cnt);
      r.id_store_full = full_q;
      reports_due.insert(reports_due.size(), r);
    end
  endtask

  // drive one item, random gap first; valid stays up until the next gap or drain
  task automatic send_item(logic signed [19:0] rx, ry, ax, ay, logic [15:0] id,
                           bit present, bit last);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.robot_x <= rx; in_ch.robot_y <= ry;
    in_ch.agent_x <= ax; in_ch.agent_y <= ay;
    in_ch.agent_id <= id; in_ch.agent_present <= present; in_ch.frame_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_frame(rx, ry, ax, ay, id, present, last);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    wait_drained();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pmdm_pkg::RegStartX: start_q = longint'($signed(val));
      pmdm_pkg::RegGoalX: goal_q = longint'($signed(val));
      default: coll_q = val & 20'h1FFFF;
    endcase
  endtask

  // receiver: random wait per result, plus a long hold on request
  always @(posedge clk) begin
    int unsigned wait_n;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (holds_done != hold_reqs) begin
      holds_done <= hold_reqs;
      hold_cycles <= LongHold;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      wait_n = $urandom_range(0, 7);
      rx_wait <= wait_n;
      out_ch.ready <= (wait_n == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_ch.ready <= (rx_wait == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    report_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.frame_min_mm, out_ch.overall_min_mm,
              out_ch.mean_min_mm, out_ch.collision_count, out_ch.id_store_full};
      results_seen++;
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = reports_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [19:0] rand_pos();
    return 20'($urandom);
  endfunction

  task automatic test_directed();
    // extremes, empty frame, collisions, duplicate ids
    send_item(20'sd5000, 20'sd0, 20'sd5000, 20'sd100, 16'd7, 1, 0);
    send_item(20'sd5000, 20'sd0, 20'sd5050, 20'sd0, 16'd7, 1, 1);
    send_item(20'sd5000, 20'sd0, 20'sd0, 20'sd0, 16'd0, 0, 1);
    send_item(20'sd500, 20'sd0, 20'sd500, 20'sd0, 16'd1, 1, 1);
    send_item(20'sd20000, 20'sd0, 20'sd20000, 20'sd0, 16'd2, 1, 1);
    send_item(20'sd1000, 20'sd0, 20'sd1000, 20'sd0, 16'd3, 1, 1);
    send_item(20'sd18000, 20'sd0, 20'sd18000, 20'sd199, 16'hFFFF, 1, 1);
    send_item(20'sd18000, 20'sd0, 20'sd18000, 20'sd200, 16'd9, 1, 1);
    send_item(20'sd10000, -20'sd524288, 20'sd10000, 20'sd524287, 16'd4, 1, 0);
    send_item(20'sd500, 20'sd0, 20'sd500, 20'sd0, 16'd5, 1, 1);
    write_reg(pmdm_pkg::RegStartX, -20'sd524288);
    write_reg(pmdm_pkg::RegGoalX, 20'sd524287);
    write_reg(pmdm_pkg::RegCollision, 20'd100000);
    send_item(20'sd524287, -20'sd524288, -20'sd524288, 20'sd524287, 16'hAAAA, 1, 0);
    send_item(-20'sd524287, 20'sd524287, 20'sd524287, -20'sd524288, 16'h5555, 1, 1);
    send_item(20'sd0, 20'sd0, 20'sd0, 20'sd0, 16'h5555, 1, 1);
    send_item(-20'sd524288, 20'sd0, 20'sd0, 20'sd0, 16'd1, 1, 1);
    write_reg(pmdm_pkg::RegStartX, 20'sd100);
    write_reg(pmdm_pkg::RegGoalX, 20'sd100);
    send_item(20'sd100, 20'sd0, 20'sd0, 20'sd0, 16'd1, 1, 1);
    send_item(20'sd101, 20'sd0, 20'sd0, 20'sd0, 16'd1, 1, 1);
    write_reg(pmdm_pkg::RegCollision, 20'd0);
  endtask

  task automatic run_frames(int n_items, int coll_pct);
    logic signed [19:0] rx, ry;
    int n, left;
    left = n_items;
    while (left > 0) begin
      n = $urandom_range(1, 6);
      rx = ($urandom_range(0, 9) == 0) ? rand_pos() : 20'($urandom_range(0, 20000));
      ry = rand_pos();
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 99) < coll_pct)
          send_item(rx, ry, rx + 20'($urandom_range(0, 300)) - 20'sd150,
                    ry + 20'($urandom_range(0, 300)) - 20'sd150,
                    16'($urandom_range(0, 90)), $urandom_range(0, 9) != 0, k == n - 1);
        else
          send_item(rx, ry, rand_pos(), rand_pos(), 16'($urandom),
                    $urandom_range(0, 9) != 0, k == n - 1);
        left--;
      end
      if ($urandom_range(0, 20) == 0) begin
        left--;
        send_item(rx, ry, 20'sd0, 20'sd0, 16'd0, 0, 1);
      end
    end
  endtask

  task automatic test_random_settings();
    write_reg(pmdm_pkg::RegStartX, 20'sd1000);
    write_reg(pmdm_pkg::RegGoalX, 20'sd18000);
    write_reg(pmdm_pkg::RegCollision, 20'd200);
    run_frames(500, 40);
    write_reg(pmdm_pkg::RegStartX, 20'sd3000);
    write_reg(pmdm_pkg::RegGoalX, 20'sd12000);
    write_reg(pmdm_pkg::RegCollision, 20'd100000);
    run_frames(300, 20);
    write_reg(pmdm_pkg::RegStartX, -20'sd524288);
    write_reg(pmdm_pkg::RegGoalX, 20'sd524287);
    write_reg(pmdm_pkg::RegCollision, 20'd150);
    run_frames(350, 50);
  endtask

  task automatic test_backpressure();
    hold_reqs++;
    run_frames(100, 30);
    wait_drained();
    run_frames(80, 30);
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.robot_x <= '0; in_ch.robot_y <= '0; in_ch.agent_x <= '0; in_ch.agent_y <= '0;
    in_ch.agent_id <= '0; in_ch.agent_present <= 1'b0; in_ch.frame_last <= 1'b0;
    reset_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_settings();
    test_backpressure();
    wait_drained();
    $display("covered directed extremes, three register settings, random frames,");
    $display("a long output stall; %0d results checked", results_seen);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/pmdm_pkg.sv
rtl/pmdm_if.sv
rtl/pmdm_ctrl.sv
rtl/pmdm_dp.sv
rtl/proximity_min_distance_monitor_unit.sv
rtl/pmdm_checker.sv
tb/sv/tb_proximity_min_distance_monitor_unit.sv
